// File: rtl/tsc_pkg.sv
// package for the tournament scc source count unit
// types, sizes and state codes shared by the unit and the bench; no dependencies
`timescale 1ns / 1ps
package tsc_pkg;
   localparam int MaxVertices = 64;
   localparam int VertexWidth = $clog2(MaxVertices);
   localparam int CountWidth = VertexWidth + 1;

   localparam logic ReqLoad = 1'b0;
   localparam logic ReqRun = 1'b1;

   typedef struct packed {
      logic       req_type;
      logic [5:0] row_vertex;
      logic [5:0] col_vertex;
      logic       forward;
   } req_type_type;

   typedef struct packed {
      logic [6:0] source_vertex_count;
      logic [6:0] component_count;
   } rsp_type_type;

   typedef enum logic [4:0] {
      ST_IDLE,
      ST_BOOT,
      ST_LOAD_RD,
      ST_LOAD_WR,
      ST_CLEAR,
      ST_ROOT,
      ST_ROOT_CHK,
      ST_FRAME,
      ST_FRAME_WT,
      ST_SCAN,
      ST_NBR_WT,
      ST_NBR,
      ST_FINISH,
      ST_POP_RD,
      ST_POP_WT,
      ST_RET_RD,
      ST_RET_WT,
      ST_RET,
      ST_SRC_INIT,
      ST_EDGE_ROW,
      ST_EDGE_RWT,
      ST_EDGE_COL,
      ST_EDGE_CWT,
      ST_EDGE_CHK,
      ST_TOT_RD,
      ST_TOT_WT,
      ST_TOT_ADD,
      ST_WIPE,
      ST_DONE
   } state_type;
endpackage

// File: rtl/tsc_ram.sv
// generic single-port-write, one-read synchronous ram with registered read
// no dependencies
`timescale 1ns / 1ps
module tsc_ram #(
   parameter int Width = 8,
   parameter int Depth = 64
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(Depth)-1:0] wr_addr,
   input  logic [Width-1:0]         wr_data,
   input  logic [$clog2(Depth)-1:0] rd_addr,
   output logic [Width-1:0]         rd_data
);
   logic [Width-1:0] mem_ff [Depth];
   logic [Width-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;
endmodule

// File: rtl/tournament_scc_source_count_unit.sv
// tournament scc source count unit: tarjan scc over an adjacency ram
// depends on tsc_pkg and tsc_ram
// a pair load keeps busy high through a row rmw, then a col rmw
// a run keeps busy high throughout: store clear, tarjan, flag init, edge pass, totals, wipe
// synchronous active-high reset sets vertex_count to 1 and clears the matrix
// one rsp_valid strobe per run, in the first cycle with busy low; the receiver cannot stall
`timescale 1ns / 1ps
module tournament_scc_source_count_unit (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  start,
   output logic                  busy,
   input  tsc_pkg::req_type_type req_data,
   output logic                  rsp_valid,
   output tsc_pkg::rsp_type_type rsp_data,
   input  logic                  csr_valid,
   output logic                  csr_ready,
   input  logic [6:0]            csr_data
);
   import tsc_pkg::*;

   state_type state_ff, state_in;
   logic [6:0] vcount_ff;
   logic [6:0] n_ff, n_in;
   req_type_type req_ff, req_in;
   logic [5:0] i_ff, i_in;          // generic vertex cursor
   logic [6:0] j_ff, j_in;          // scan index
   logic [5:0] v_ff, v_in;
   logic [6:0] low_v_ff, low_v_in;
   logic [6:0] disc_v_ff, disc_v_in;
   logic [6:0] depth_ff, depth_in;
   logic [6:0] top_ff, top_in;
   logic [6:0] stamp_ff, stamp_in;
   logic [6:0] comp_ff, comp_in;
   logic [6:0] total_ff, total_in;
   logic [6:0] lbl_i_ff, lbl_i_in;
   logic [63:0] row_ff, row_in;
   logic [63:0] row_clr_ff, row_clr_in;
   logic       clear_done_ff, clear_done_in;
   logic       rsp_valid_ff, rsp_valid_in;

   // memories
   logic adj_we; logic [5:0] adj_wa, adj_ra; logic [63:0] adj_wd, adj_rd;
   logic dsc_we; logic [5:0] dsc_wa, dsc_ra; logic [6:0] dsc_wd, dsc_rd;
   logic low_we; logic [5:0] low_wa, low_ra; logic [6:0] low_wd, low_rd;
   logic lbl_we; logic [5:0] lbl_wa, lbl_ra; logic [6:0] lbl_wd, lbl_rd;
   logic vst_we; logic [5:0] vst_wa, vst_ra; logic [5:0] vst_wd, vst_rd;
   logic cst_we; logic [5:0] cst_wa, cst_ra; logic [12:0] cst_wd, cst_rd;
   logic src_we; logic [5:0] src_wa, src_ra; logic [0:0] src_wd, src_rd;

   tsc_ram #(.Width(64), .Depth(MaxVertices)) u_adj (.clock, .wr_en(adj_we),
      .wr_addr(adj_wa), .wr_data(adj_wd), .rd_addr(adj_ra), .rd_data(adj_rd));
   tsc_ram #(.Width(7), .Depth(MaxVertices)) u_dsc (.clock, .wr_en(dsc_we),
      .wr_addr(dsc_wa), .wr_data(dsc_wd), .rd_addr(dsc_ra), .rd_data(dsc_rd));
   tsc_ram #(.Width(7), .Depth(MaxVertices)) u_low (.clock, .wr_en(low_we),
      .wr_addr(low_wa), .wr_data(low_wd), .rd_addr(low_ra), .rd_data(low_rd));
   tsc_ram #(.Width(7), .Depth(MaxVertices)) u_lbl (.clock, .wr_en(lbl_we),
      .wr_addr(lbl_wa), .wr_data(lbl_wd), .rd_addr(lbl_ra), .rd_data(lbl_rd));
   tsc_ram #(.Width(6), .Depth(MaxVertices)) u_vst (.clock, .wr_en(vst_we),
      .wr_addr(vst_wa), .wr_data(vst_wd), .rd_addr(vst_ra), .rd_data(vst_rd));
   tsc_ram #(.Width(13), .Depth(MaxVertices)) u_cst (.clock, .wr_en(cst_we),
      .wr_addr(cst_wa), .wr_data(cst_wd), .rd_addr(cst_ra), .rd_data(cst_rd));
   tsc_ram #(.Width(1), .Depth(MaxVertices)) u_src (.clock, .wr_en(src_we),
      .wr_addr(src_wa), .wr_data(src_wd), .rd_addr(src_ra), .rd_data(src_rd));

   assign busy = (state_ff != ST_IDLE);
   assign csr_ready = (state_ff == ST_IDLE);
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data.source_vertex_count = total_ff;
   assign rsp_data.component_count = comp_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_BOOT;
         vcount_ff <= 7'd1;
         rsp_valid_ff <= 1'b0;
         i_ff <= '0;
      end else begin
         state_ff <= state_in;
         rsp_valid_ff <= rsp_valid_in;
         i_ff <= i_in;
         if (csr_valid && csr_ready) begin
            vcount_ff <= csr_data;
         end
      end
      n_ff <= n_in; req_ff <= req_in; j_ff <= j_in; v_ff <= v_in;
      low_v_ff <= low_v_in; disc_v_ff <= disc_v_in; depth_ff <= depth_in;
      top_ff <= top_in; stamp_ff <= stamp_in; comp_ff <= comp_in;
      total_ff <= total_in; lbl_i_ff <= lbl_i_in; row_ff <= row_in;
      row_clr_ff <= row_clr_in; clear_done_ff <= clear_done_in;
   end

   logic [6:0] stamp_nx;
   logic [5:0] j6;
   assign j6 = j_ff[5:0];

   always_comb begin
      state_in = state_ff;
      n_in = n_ff; req_in = req_ff; i_in = i_ff; j_in = j_ff; v_in = v_ff;
      low_v_in = low_v_ff; disc_v_in = disc_v_ff; depth_in = depth_ff;
      top_in = top_ff; stamp_in = stamp_ff; comp_in = comp_ff;
      total_in = total_ff; lbl_i_in = lbl_i_ff; row_in = row_ff;
      row_clr_in = row_clr_ff; clear_done_in = clear_done_ff;
      rsp_valid_in = 1'b0;
      stamp_nx = stamp_ff + 7'd1;
      adj_we = 1'b0; adj_wa = i_ff; adj_wd = '0; adj_ra = i_ff;
      dsc_we = 1'b0; dsc_wa = i_ff; dsc_wd = '0; dsc_ra = i_ff;
      low_we = 1'b0; low_wa = v_ff; low_wd = '0; low_ra = v_ff;
      lbl_we = 1'b0; lbl_wa = i_ff; lbl_wd = '0; lbl_ra = i_ff;
      vst_we = 1'b0; vst_wa = top_ff[5:0]; vst_wd = '0; vst_ra = top_ff[5:0];
      cst_we = 1'b0; cst_wa = depth_ff[5:0]; cst_wd = '0; cst_ra = depth_ff[5:0];
      src_we = 1'b0; src_wa = i_ff; src_wd = '0; src_ra = i_ff;
      case (state_ff)
         ST_IDLE: begin
            if (start) begin
               req_in = req_data;
               if (req_data.req_type == ReqRun) begin
                  n_in = (vcount_ff > 7'(MaxVertices)) ? 7'(MaxVertices) : vcount_ff;
                  i_in = '0; stamp_in = '0; comp_in = '0; top_in = '0;
                  total_in = '0;
                  state_in = ST_CLEAR;
               end else if (req_data.row_vertex != req_data.col_vertex) begin
                  i_in = req_data.row_vertex;
                  state_in = ST_LOAD_RD;
               end
            end
         end
         // matrix clearing pass after reset
         ST_BOOT: begin
            adj_we = 1'b1; adj_wd = '0;
            i_in = i_ff + 6'd1;
            if (i_ff == 6'(MaxVertices - 1)) begin
               state_in = ST_IDLE;
            end
         end
         // read row r, then read row c while writing r, then write c
         ST_LOAD_RD: begin
            adj_ra = req_ff.row_vertex;
            state_in = ST_LOAD_WR;
            i_in = req_ff.col_vertex;
            clear_done_in = 1'b0;
         end
         ST_LOAD_WR: begin
            if (!clear_done_ff) begin
               adj_we = 1'b1; adj_wa = req_ff.row_vertex;
               adj_wd = adj_rd;
               adj_wd[req_ff.col_vertex] = req_ff.forward;
               adj_ra = req_ff.col_vertex;
               clear_done_in = 1'b1;
            end else begin
               adj_we = 1'b1; adj_wa = req_ff.col_vertex;
               adj_wd = adj_rd;
               adj_wd[req_ff.row_vertex] = ~req_ff.forward;
               state_in = ST_IDLE;
            end
         end
         ST_CLEAR: begin
            dsc_we = 1'b1; lbl_we = 1'b1;
            i_in = i_ff + 6'd1;
            if (i_ff == 6'(MaxVertices - 1)) begin
               i_in = '0;
               state_in = (n_ff == 7'd0) ? ST_SRC_INIT : ST_ROOT;
            end
         end
         ST_ROOT: begin
            dsc_ra = i_ff;
            state_in = ST_ROOT_CHK;
         end
         ST_ROOT_CHK: begin
            if (dsc_rd == 7'd0) begin
               // start visit of root
               stamp_in = stamp_nx;
               dsc_we = 1'b1; dsc_wa = i_ff; dsc_wd = stamp_nx;
               v_in = i_ff; low_we = 1'b1; low_wa = i_ff; low_wd = stamp_nx;
               vst_we = 1'b1; vst_wa = top_ff[5:0]; vst_wd = i_ff;
               top_in = top_ff + 7'd1;
               cst_we = 1'b1; cst_wa = 6'd0; cst_wd = {7'd0, i_ff};
               depth_in = 7'd1;
               state_in = ST_FRAME;
            end else if (7'(i_ff) + 7'd1 >= n_ff) begin
               i_in = '0; state_in = ST_SRC_INIT;
            end else begin
               i_in = i_ff + 6'd1; state_in = ST_ROOT;
            end
         end
         // fetch top frame: call stack, then row, low and disc of v
         ST_FRAME: begin
            cst_ra = 6'(depth_ff - 7'd1);
            state_in = ST_FRAME_WT;
         end
         ST_FRAME_WT: begin
            v_in = cst_rd[5:0]; j_in = cst_rd[12:6];
            adj_ra = cst_rd[5:0]; low_ra = cst_rd[5:0]; dsc_ra = cst_rd[5:0];
            state_in = ST_SCAN;
            clear_done_in = 1'b0;
         end
         ST_SCAN: begin
            if (!clear_done_ff) begin
               row_in = adj_rd; low_v_in = low_rd; disc_v_in = dsc_rd;
               clear_done_in = 1'b1;
            end else if (j_ff < n_ff && !row_ff[j6]) begin
               j_in = j_ff + 7'd1;
            end else if (j_ff < n_ff) begin
               cst_we = 1'b1; cst_wa = 6'(depth_ff - 7'd1);
               cst_wd = {j_ff + 7'd1, v_ff};
               dsc_ra = j6; lbl_ra = j6;
               state_in = ST_NBR_WT;
            end else begin
               state_in = ST_FINISH;
            end
         end
         // keep the neighbor address on the read ports
         ST_NBR_WT: begin
            dsc_ra = j6; lbl_ra = j6;
            state_in = ST_NBR;
         end
         ST_NBR: begin
            state_in = ST_FRAME;
            if (dsc_rd == 7'd0) begin
               if (depth_ff < 7'(MaxVertices) && top_ff < 7'(MaxVertices)) begin
                  stamp_in = stamp_nx;
                  dsc_we = 1'b1; dsc_wa = j6; dsc_wd = stamp_nx;
                  low_we = 1'b1; low_wa = j6; low_wd = stamp_nx;
                  vst_we = 1'b1; vst_wd = j6;
                  top_in = top_ff + 7'd1;
                  cst_we = 1'b1; cst_wd = {7'd0, j6};
                  depth_in = depth_ff + 7'd1;
               end
            end else if (lbl_rd == 7'd0 && dsc_rd < low_v_ff) begin
               low_we = 1'b1; low_wd = dsc_rd;
            end
         end
         ST_FINISH: begin
            if (low_v_ff == disc_v_ff) begin
               comp_in = comp_ff + 7'd1;
               state_in = ST_POP_RD;
            end else begin
               state_in = ST_RET_RD;
            end
         end
         ST_POP_RD: begin
            if (top_ff == 7'd0) begin
               state_in = ST_RET_RD;
            end else begin
               vst_ra = 6'(top_ff - 7'd1);
               top_in = top_ff - 7'd1;
               state_in = ST_POP_WT;
            end
         end
         ST_POP_WT: begin
            lbl_we = 1'b1; lbl_wa = vst_rd; lbl_wd = comp_ff;
            state_in = (vst_rd == v_ff) ? ST_RET_RD : ST_POP_RD;
         end
         ST_RET_RD: begin
            depth_in = depth_ff - 7'd1;
            if (depth_ff == 7'd1) begin
               i_in = (7'(i_ff) + 7'd1 >= n_ff) ? i_ff : i_ff + 6'd1;
               if (7'(i_ff) + 7'd1 >= n_ff) begin
                  i_in = '0; state_in = ST_SRC_INIT;
               end else begin
                  state_in = ST_ROOT;
               end
            end else begin
               cst_ra = 6'(depth_ff - 7'd2);
               state_in = ST_RET_WT;
            end
         end
         ST_RET_WT: begin
            low_ra = cst_rd[5:0];
            j_in = {1'b0, cst_rd[5:0]};
            state_in = ST_RET;
         end
         ST_RET: begin
            if (low_v_ff < low_rd) begin
               low_we = 1'b1; low_wa = j6; low_wd = low_v_ff;
            end
            state_in = ST_FRAME;
         end
         ST_SRC_INIT: begin
            src_we = 1'b1; src_wd = 1'b1;
            i_in = i_ff + 6'd1;
            if (i_ff == 6'(MaxVertices - 1)) begin
               i_in = '0;
               state_in = (n_ff == 7'd0) ? ST_TOT_RD : ST_EDGE_ROW;
            end
         end
         // per row i: read row and label, then test every column j
         ST_EDGE_ROW: begin
            adj_ra = i_ff; lbl_ra = i_ff;
            state_in = ST_EDGE_RWT;
         end
         ST_EDGE_RWT: begin
            row_in = adj_rd; lbl_i_in = lbl_rd; j_in = '0;
            state_in = ST_EDGE_COL;
         end
         ST_EDGE_COL: begin
            if (j_ff >= n_ff) begin
               if (7'(i_ff) + 7'd1 >= n_ff) begin
                  i_in = '0; state_in = ST_TOT_RD;
               end else begin
                  i_in = i_ff + 6'd1; state_in = ST_EDGE_ROW;
               end
            end else if (!row_ff[j6]) begin
               j_in = j_ff + 7'd1;
            end else begin
               lbl_ra = j6;
               state_in = ST_EDGE_CWT;
            end
         end
         ST_EDGE_CWT: begin
            lbl_ra = j6;
            state_in = ST_EDGE_CHK;
         end
         ST_EDGE_CHK: begin
            if (lbl_rd != lbl_i_ff && lbl_rd != 7'd0) begin
               src_we = 1'b1; src_wa = 6'(lbl_rd - 7'd1); src_wd = 1'b0;
            end
            j_in = j_ff + 7'd1;
            state_in = ST_EDGE_COL;
         end
         ST_TOT_RD: begin
            if (7'(i_ff) >= n_ff) begin
               i_in = '0; state_in = ST_WIPE;
            end else begin
               lbl_ra = i_ff;
               state_in = ST_TOT_WT;
            end
         end
         ST_TOT_WT: begin
            src_ra = 6'(lbl_rd - 7'd1);
            lbl_i_in = lbl_rd;
            state_in = ST_TOT_ADD;
         end
         ST_TOT_ADD: begin
            if (lbl_i_ff != 7'd0 && src_rd[0]) begin
               total_in = total_ff + 7'd1;
            end
            if (i_ff == 6'(MaxVertices - 1)) begin
               i_in = '0; state_in = ST_WIPE;
            end else begin
               i_in = i_ff + 6'd1; state_in = ST_TOT_RD;
            end
         end
         ST_WIPE: begin
            adj_we = 1'b1; adj_wd = '0;
            i_in = i_ff + 6'd1;
            if (i_ff == 6'(MaxVertices - 1)) begin
               state_in = ST_DONE;
            end
         end
         ST_DONE: begin
            rsp_valid_in = 1'b1;
            state_in = ST_IDLE;
         end
         default: state_in = ST_IDLE;
      endcase
   end
endmodule

// File: bench/tsc_scoreboard.sv
// checker for the tournament scc source count unit: watches the request,
// response and csr channels, predicts each run and compares the response
// depends on tsc_pkg
`timescale 1ns / 1ps
module tsc_scoreboard (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  start,
   input  logic                  busy,
   input  tsc_pkg::req_type_type req_data,
   input  logic                  rsp_valid,
   input  tsc_pkg::rsp_type_type rsp_data,
   input  logic                  csr_valid,
   input  logic                  csr_ready,
   input  logic [6:0]            csr_data,
   output int                    fail_count,
   output int                    pending
);
   import tsc_pkg::*;

   logic [63:0]  matrix [MaxVertices];
   logic [6:0]   vertex_count;
   rsp_type_type expected_counts [$];

   // tarjan over the loaded tournament, then count vertices in source components
   function automatic rsp_type_type count_sources();
      int disc [64];
      int low [64];
      int label [64];
      int vstack [64];
      int frame_v [64];
      int frame_j [64];
      bit is_source [64];
      int n, stamp, comps, top, depth, v, j, y, p, total;
      rsp_type_type r;
      n = (vertex_count > MaxVertices) ? MaxVertices : int'(vertex_count);
      stamp = 0;
      comps = 0;
      top = 0;
      total = 0;
      for (int i = 0; i < 64; i++) begin
         disc[i] = 0;
         label[i] = 0;
      end
      for (int root = 0; root < n; root++) begin
         if (disc[root] != 0) continue;
         depth = 0;
         stamp++;
         disc[root] = stamp;
         low[root] = stamp;
         vstack[top++] = root;
         frame_v[depth] = root;
         frame_j[depth] = 0;
         depth++;
         while (depth > 0) begin
            v = frame_v[depth-1];
            j = frame_j[depth-1];
            while (j < n && !matrix[v][j]) j++;
            if (j < n) begin
               frame_j[depth-1] = j + 1;
               if (disc[j] == 0) begin
                  if (depth < MaxVertices && top < MaxVertices) begin
                     stamp++;
                     disc[j] = stamp;
                     low[j] = stamp;
                     vstack[top++] = j;
                     frame_v[depth] = j;
                     frame_j[depth] = 0;
                     depth++;
                  end
               end else if (label[j] == 0 && disc[j] < low[v]) begin
                  low[v] = disc[j];
               end
               continue;
            end
            if (low[v] == disc[v]) begin
               comps++;
               do begin
                  if (top == 0) break;
                  y = vstack[--top];
                  label[y] = comps;
               end while (y != v);
            end
            depth--;
            if (depth > 0) begin
               p = frame_v[depth-1];
               if (low[v] < low[p]) low[p] = low[v];
            end
         end
      end
      for (int c = 0; c < comps; c++) is_source[c] = 1'b1;
      for (int a = 0; a < n; a++)
         for (int b = 0; b < n; b++)
            if (matrix[a][b] && label[b] != label[a] && label[b] >= 1)
               is_source[label[b]-1] = 1'b0;
      for (int a = 0; a < n; a++)
         if (label[a] >= 1 && is_source[label[a]-1]) total++;
      r.source_vertex_count = total[6:0];
      r.component_count = comps[6:0];
      return r;
   endfunction

   always @(posedge clock) begin
      rsp_type_type want;
      if (reset) begin
         for (int i = 0; i < MaxVertices; i++) matrix[i] = '0;
         vertex_count = 7'd1;
         expected_counts.delete();
         fail_count = 0;
      end else begin
         if (csr_valid && csr_ready) vertex_count = csr_data;
         if (start && !busy) begin
            if (req_data.req_type == ReqRun) begin
               expected_counts.insert(expected_counts.size(), count_sources());
               for (int i = 0; i < MaxVertices; i++) matrix[i] = '0;
            end else if (req_data.row_vertex != req_data.col_vertex) begin
               if (req_data.forward) begin
                  matrix[req_data.row_vertex][req_data.col_vertex] = 1'b1;
                  matrix[req_data.col_vertex][req_data.row_vertex] = 1'b0;
               end else begin
                  matrix[req_data.col_vertex][req_data.row_vertex] = 1'b1;
                  matrix[req_data.row_vertex][req_data.col_vertex] = 1'b0;
               end
            end
         end
         if (rsp_valid) begin
            if (expected_counts.size() == 0) begin
               $error("response with no run outstanding");
               fail_count = fail_count + 1;
            end else begin
               want = expected_counts.pop_front();
               if (rsp_data.source_vertex_count !== want.source_vertex_count) begin
                  $error("source_vertex_count: expected %0d, got %0d",
                         want.source_vertex_count, rsp_data.source_vertex_count);
                  fail_count = fail_count + 1;
               end
               if (rsp_data.component_count !== want.component_count) begin
                  $error("component_count: expected %0d, got %0d",
                         want.component_count, rsp_data.component_count);
                  fail_count = fail_count + 1;
               end
            end
         end
      end
      pending <= expected_counts.size();
   end
endmodule

// File: bench/tb_tournament_scc_source_count_unit.sv
// top of the bench for the tournament scc source count unit: clock, reset,
// request and csr stimulus, watchdog and verdict
// depends on tsc_pkg, tsc_scoreboard and the unit itself
`timescale 1ns / 1ps
module tb_tournament_scc_source_count_unit;
   import tsc_pkg::*;

   localparam int StallLimit = 200000;

   logic         clock;
   logic         reset;
   logic         start;
   logic         busy;
   req_type_type req_data;
   logic         rsp_valid;
   rsp_type_type rsp_data;
   logic         csr_valid;
   logic         csr_ready;
   logic [6:0]   csr_data;
   int           fail_count;
   int           pending;
   int           request_count;
   int           run_count;
   int           big_runs;
   int           quiet_cycles;
   bit           no_idle;

   tournament_scc_source_count_unit dut (
      .clock(clock), .reset(reset), .start(start), .busy(busy),
      .req_data(req_data), .rsp_valid(rsp_valid), .rsp_data(rsp_data),
      .csr_valid(csr_valid), .csr_ready(csr_ready), .csr_data(csr_data)
   );

   tsc_scoreboard checker_i (
      .clock(clock), .reset(reset), .start(start), .busy(busy),
      .req_data(req_data), .rsp_valid(rsp_valid), .rsp_data(rsp_data),
      .csr_valid(csr_valid), .csr_ready(csr_ready), .csr_data(csr_data),
      .fail_count(fail_count), .pending(pending)
   );

   initial begin
      clock = 1'b0;
      forever #2 clock = ~clock;
   end

   always @(posedge clock) begin
      if (reset || (start && !busy) || rsp_valid || (csr_valid && csr_ready))
         quiet_cycles <= 0;
      else
         quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= StallLimit) begin
         $display("Verification failed");
         $finish;
      end
   end

   task automatic random_gap();
      if (!no_idle && $urandom_range(99) < 25) begin
         start <= 1'b0;
         repeat ($urandom_range(1, 4)) @(posedge clock);
      end
   endtask

   task automatic send_request(logic kind, int row, int col, logic fwd);
      random_gap();
      start <= 1'b1;
      req_data <= '{req_type: kind, row_vertex: row[5:0], col_vertex: col[5:0],
                    forward: fwd};
      do @(posedge clock); while (busy !== 1'b0);
      request_count++;
   endtask

   // wait until the unit is idle and every response is in, then write the register
   task automatic write_vertex_count(int value);
      start <= 1'b0;
      do @(posedge clock); while (pending != 0 || busy !== 1'b0);
      repeat (10) @(posedge clock);
      csr_valid <= 1'b1;
      csr_data <= value[6:0];
      do @(posedge clock); while (csr_ready !== 1'b1);
      csr_valid <= 1'b0;
   endtask

   task automatic run_tarjan();
      send_request(ReqRun, $urandom_range(63), $urandom_range(63), 1'($urandom));
      run_count++;
   endtask

   // a full tournament on vertices 0..n-1 with random directions
   task automatic load_tournament(int n);
      for (int a = 0; a < n; a++)
         for (int b = a + 1; b < n; b++)
            if ($urandom_range(1))
               send_request(ReqLoad, a, b, 1'($urandom));
            else
               send_request(ReqLoad, b, a, 1'($urandom));
   endtask

   initial begin
      int n, span, loads, r, c, pick;
      reset = 1'b1;
      start = 1'b0;
      req_data = '0;
      csr_valid = 1'b0;
      csr_data = '0;
      request_count = 0;
      run_count = 0;
      big_runs = 0;
      no_idle = 1'b0;
      repeat (6) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // directed: default count of one, then a small graph with the odd loads
      run_tarjan();
      write_vertex_count(4);
      send_request(ReqLoad, 0, 1, 1'b1);
      send_request(ReqLoad, 1, 2, 1'b1);
      send_request(ReqLoad, 2, 0, 1'b1);   // row above column
      send_request(ReqLoad, 3, 3, 1'b1);   // self pair, dropped
      send_request(ReqLoad, 0, 3, 1'b1);
      send_request(ReqLoad, 0, 3, 1'b0);   // reload flips the direction
      send_request(ReqLoad, 5, 63, 1'b1);  // outside the run's vertices
      send_request(ReqLoad, 63, 62, 1'b0);
      run_tarjan();
      write_vertex_count(0);
      send_request(ReqLoad, 0, 1, 1'b1);
      run_tarjan();
      write_vertex_count(127);
      send_request(ReqLoad, 63, 0, 1'b1);
      send_request(ReqLoad, 42, 21, 1'b0);
      run_tarjan();
      write_vertex_count(64);
      load_tournament(5);
      run_tarjan();
      big_runs = 2;

      while (request_count < 950) begin
         no_idle = (request_count > 350 && request_count < 500);
         pick = $urandom_range(99);
         if (pick < 70) n = $urandom_range(2, 10);
         else if (pick < 88) n = $urandom_range(11, 20);
         else if (big_runs < 4 && pick < 92) begin
            n = ($urandom_range(1)) ? 64 : 65 + $urandom_range(62);
            big_runs++;
         end else n = $urandom_range(1) ? 0 : 1;
         write_vertex_count(n);
         span = (n > 62) ? 63 : n + 1;
         if (n >= 2 && n <= 12 && $urandom_range(99) < 70) load_tournament(n);
         loads = $urandom_range(0, 25);
         for (int k = 0; k < loads; k++) begin
            pick = $urandom_range(99);
            if (pick < 15) begin
               r = $urandom_range(63);
               c = $urandom_range(63);
            end else if (pick < 20) begin
               r = $urandom_range(63);
               c = r;
            end else begin
               r = $urandom_range(span);
               c = $urandom_range(span);
            end
            send_request(ReqLoad, r, c, 1'($urandom));
         end
         run_tarjan();
      end

      start <= 1'b0;
      do @(posedge clock); while (pending != 0);
      repeat (200) @(posedge clock);
      $display("covered %0d requests including %0d runs, vertex counts 0 to 127",
               request_count, run_count);
      if (fail_count == 0 && pending == 0)
         $display("Verification passed");
      else
         $display("Verification failed");
      $finish;
   end
endmodule
